// ===== hw/rtl/bfm_pkg.sv =====
// shared types, sizes and hash constants for the bloom filter membership block
package bfm_pkg;

	localparam int MAX_FILTER_BITS = 1048576;
	localparam int MAX_KEY_BYTES   = 256;
	localparam int MAX_HASHES      = 32;

	localparam int FB_W    = 21;
	localparam int HC_W    = 6;
	localparam int KLEN_W  = $clog2(MAX_KEY_BYTES + 1);
	localparam int KADDR_W = $clog2(MAX_KEY_BYTES);
	localparam int FWORDS  = MAX_FILTER_BITS / 64;
	localparam int FADDR_W = $clog2(FWORDS);
	localparam int QDEPTH  = 4;
	localparam int QA_W    = $clog2(QDEPTH);
	localparam int QC_W    = $clog2(QDEPTH + 1);

	localparam logic [FB_W-1:0] FB_RESET = FB_W'(65536);
	localparam logic [HC_W-1:0] HC_RESET = HC_W'(7);

	localparam logic [63:0] MM_C1  = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2  = 64'h4cf5ad432745937f;
	localparam logic [63:0] MM_F1  = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MM_F2  = 64'hc4ceb93fe53ef63b;
	localparam logic [63:0] MM_HC1 = 64'h0000000052dce729;
	localparam logic [63:0] MM_HC2 = 64'h0000000038495ab5;

	typedef enum logic [0:0] {
		CFG_FILTER_BITS = 1'b0,
		CFG_HASH_COUNT  = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FN_ADD    = 2'd0,
		FN_QUERY  = 2'd1,
		FN_STATUS = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DISABLED   = 2'd0,
		ST_PENDING    = 2'd1,
		ST_COMPACTING = 2'd2,
		ST_ENABLED    = 2'd3
	} status_t;

	typedef struct packed {
		func_t       func;
		logic [7:0]  key_byte;
		logic        key_last;
		logic [31:0] collection_id;
		status_t     target_status;
	} in_t;

	typedef struct packed {
		logic            maybe_present;
		logic            newly_added;
		status_t         current_status;
		logic [31:0]     keys_counted;
		logic [FB_W-1:0] active_bits;
		logic [HC_W-1:0] active_hashes;
		logic            key_too_long;
	} out_t;

	typedef struct packed {
		logic [FB_W-1:0] bits;
		logic [HC_W-1:0] hashes;
	} eff_cfg_t;

endpackage

// ===== hw/rtl/bloom_filter_membership.sv =====
// Bloom filter membership block: key bytes stream in one beat each; the beat with key_last
// closes the key and produces one result beat, as does each status request. A byte that does
// not close a key is written to the key store while the engine stays idle. The time a closing
// byte takes is set by the shared 32x32 multiplier that carries every MurmurHash3 product and
// by the one-bit-per-cycle modulo, and it grows with hash_count and key length. After reset and
// on every entry into disabled the filter memory is zeroed one 64-bit word per cycle, all 16384
// words; input is held off during the reset clear. A four-deep queue sits between the input
// and the engine, and a result register on the output lets the engine go on while a result
// waits to be taken.
module bloom_filter_membership import bfm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_t             in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_t            out_data,
	input  logic            cfg_we,
	input  cfg_idx_t        cfg_addr,
	input  logic [FB_W-1:0] cfg_wdata
);

	logic [FB_W-1:0] fbits_q;
	logic [HC_W-1:0] hcnt_q;
	eff_cfg_t        eff;
	logic            q_valid;
	in_t             q_data;
	logic            q_pop;
	logic            init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fbits_q <= FB_RESET;
			hcnt_q  <= HC_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_FILTER_BITS: fbits_q <= cfg_wdata;
				CFG_HASH_COUNT:  hcnt_q  <= cfg_wdata[HC_W-1:0];
				default:         fbits_q <= fbits_q;
			endcase
		end
	end

	always_comb begin
		if (fbits_q == '0) begin
			eff.bits = FB_W'(1);
		end else if (fbits_q > FB_W'(MAX_FILTER_BITS)) begin
			eff.bits = FB_W'(MAX_FILTER_BITS);
		end else begin
			eff.bits = fbits_q;
		end
		eff.hashes = (hcnt_q > HC_W'(MAX_HASHES)) ? HC_W'(MAX_HASHES) : hcnt_q;
	end

	bfm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.init_busy (init_busy),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop)
	);

	bfm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.eff       (eff),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hw/rtl/bfm_front.sv =====
// input side: takes beats, drops unused codes and queues the rest for the engine
module bfm_front import bfm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	input  logic init_busy,
	output logic q_valid,
	output in_t  q_data,
	input  logic q_pop
);

	in_t             q_mem [QDEPTH];
	logic [QA_W-1:0] wr_q;
	logic [QA_W-1:0] rd_q;
	logic [QC_W-1:0] cnt_q;
	logic            push;

	assign in_ready = (cnt_q != QC_W'(QDEPTH)) && !init_busy;
	assign push     = in_valid && in_ready && (in_data.func != FN_NONE);
	assign q_valid  = (cnt_q != '0);
	assign q_data   = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QA_W'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + QA_W'(1);
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + QC_W'(1);
				2'b01:   cnt_q <= cnt_q - QC_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/bfm_mul64.sv =====
// low 64 bits of a 64x64 product from one 32x32 multiplier, by summing shifted partial products in turn
module bfm_mul64 import bfm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] opx;
	logic [31:0] opy;
	logic [63:0] mul_w;

	always_comb begin
		case (cnt_q)
			2'd0: begin
				opx = a_q[31:0];
				opy = b_q[31:0];
			end
			2'd1: begin
				opx = a_q[31:0];
				opy = b_q[63:32];
			end
			default: begin
				opx = a_q[63:32];
				opy = b_q[31:0];
			end
		endcase
		mul_w = 64'(opx) * 64'(opy);
	end

	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk) begin
		prod_q <= mul_w;
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (busy_q) begin
			case (cnt_q)
				2'd1:    acc_q <= prod_q;
				2'd2:    acc_q <= acc_q + {prod_q[31:0], 32'h0};
				2'd3:    acc_q <= acc_q + {prod_q[31:0], 32'h0};
				default: acc_q <= acc_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/bfm_back.sv =====
// engine: key store, hashing sequencer, bit-serial modulo, filter memory and result register
module bfm_back import bfm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  in_t      q_data,
	output logic     q_pop,
	output logic     init_busy,
	input  eff_cfg_t eff,
	output logic     out_valid,
	input  logic     out_ready,
	output out_t     out_data
);

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_PROBE, S_GRD, S_GCAP, S_MUL, S_H1, S_H1B, S_H2, S_H2B,
		S_NEXT, S_FIN, S_FIN2, S_FIN3, S_FX, S_FADD, S_MOD, S_MRD, S_MCHK, S_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_K1A, OP_K1B, OP_K2A, OP_K2B, OP_FA, OP_FB
	} op_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic status_t next_status(input status_t cur, input status_t to);
		status_t n;
		n = cur;
		case (cur)
			ST_DISABLED: if (to == ST_ENABLED) n = ST_PENDING;
			ST_PENDING: begin
				if (to == ST_DISABLED) n = ST_DISABLED;
				else if (to == ST_COMPACTING) n = ST_COMPACTING;
			end
			ST_COMPACTING: begin
				if (to == ST_DISABLED) n = ST_DISABLED;
				else if (to == ST_ENABLED) n = ST_ENABLED;
			end
			default: begin
				if (to == ST_DISABLED) n = ST_DISABLED;
				else if (to == ST_COMPACTING) n = ST_COMPACTING;
			end
		endcase
		return n;
	endfunction

	state_t              state_q;
	status_t             status_q;
	logic [31:0]         key_counter_q;
	logic [KLEN_W-1:0]   len_q;
	logic                ovf_q;
	func_t               kind_q;
	logic [31:0]         seed_base_q;
	logic [HC_W-1:0]     probe_q;
	logic [63:0]         h1_q;
	logic [63:0]         h2_q;
	logic [127:0]        kbuf_q;
	logic [KLEN_W:0]     base_q;
	logic [3:0]          j_q;
	logic                bvalid_q;
	logic                full_q;
	op_t                 op_q;
	logic                fsel_q;
	logic [1:0]          fstep_q;
	logic [FB_W-1:0]     rem_q;
	logic [5:0]          mcnt_q;
	logic                fresh_q;
	logic                maybe_q;
	logic                toolong_q;
	logic [FADDR_W-1:0]  clr_q;
	logic                pend_q;
	logic                init_q;
	logic                out_valid_q;
	out_t                out_data_q;
	logic                mul_start_q;
	logic [63:0]         mul_a_q;
	logic [63:0]         mul_b_q;

	logic [7:0]          key_store [MAX_KEY_BYTES];
	logic [7:0]          ks_rd_q;
	logic [63:0]         fmem [FWORDS];
	logic [63:0]         fm_rd_q;

	logic                mul_done;
	logic [63:0]         mul_p;
	logic                active;
	logic                ks_we;
	logic [KLEN_W:0]     addr_full;
	logic                fm_we;
	logic [FADDR_W-1:0]  fm_wa;
	logic [63:0]         fm_wd;
	logic [FADDR_W-1:0]  fm_ra;
	logic [FB_W:0]       mod_r;
	logic [FB_W-1:0]     rem_n;
	logic                bitv;
	logic [127:0]        kb_n;
	logic [63:0]         fx_x;
	logic [63:0]         fx_s;
	logic [31:0]         cnt_n;
	status_t             st_n;
	logic                ovf_n;

	bfm_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.p      (mul_p)
	);

	assign active    = (status_q == ST_COMPACTING) || (status_q == ST_ENABLED);
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign init_busy = init_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		ks_we     = q_pop && (q_data.func != FN_STATUS) && (len_q != KLEN_W'(MAX_KEY_BYTES));
		addr_full = base_q + (KLEN_W + 1)'(j_q);
		fm_ra     = rem_q[FADDR_W+5:6];
		bitv      = fm_rd_q[rem_q[5:0]];
		fm_we     = 1'b0;
		fm_wa     = fm_ra;
		fm_wd     = fm_rd_q | (64'd1 << rem_q[5:0]);
		if (state_q == S_CLR) begin
			fm_we = 1'b1;
			fm_wa = clr_q;
			fm_wd = '0;
		end else if (state_q == S_MCHK && kind_q == FN_ADD) begin
			fm_we = 1'b1;
		end
		mod_r = {rem_q, h1_q[63]};
		if (mod_r >= {1'b0, eff.bits}) begin
			mod_r = mod_r - {1'b0, eff.bits};
		end
		rem_n = mod_r[FB_W-1:0];
		kb_n  = {(bvalid_q ? ks_rd_q : 8'h00), kbuf_q[127:8]};
		fx_x  = fsel_q ? h2_q : h1_q;
		fx_s  = fx_x ^ (fx_x >> 33);
		cnt_n = key_counter_q;
		if (kind_q == FN_ADD && fresh_q && key_counter_q != 32'hffffffff) begin
			cnt_n = key_counter_q + 32'd1;
		end
		st_n  = next_status(status_q, q_data.target_status);
		ovf_n = ovf_q || (len_q == KLEN_W'(MAX_KEY_BYTES));
	end

	always_ff @(posedge clk) begin
		if (ks_we) begin
			key_store[len_q[KADDR_W-1:0]] <= q_data.key_byte;
		end
		ks_rd_q <= key_store[addr_full[KADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (fm_we) begin
			fmem[fm_wa] <= fm_wd;
		end
		fm_rd_q <= fmem[fm_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			status_q      <= ST_DISABLED;
			key_counter_q <= '0;
			len_q         <= '0;
			ovf_q         <= 1'b0;
			clr_q         <= '0;
			pend_q        <= 1'b0;
			init_q        <= 1'b1;
			out_valid_q   <= 1'b0;
			mul_start_q   <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + FADDR_W'(1);
					if (clr_q == FADDR_W'(FWORDS - 1)) begin
						init_q  <= 1'b0;
						pend_q  <= 1'b0;
						state_q <= pend_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						if (q_data.func == FN_STATUS) begin
							status_q  <= st_n;
							kind_q    <= FN_STATUS;
							maybe_q   <= 1'b0;
							fresh_q   <= 1'b0;
							toolong_q <= 1'b0;
							if (st_n == ST_DISABLED && status_q != ST_DISABLED) begin
								clr_q   <= '0;
								pend_q  <= 1'b1;
								state_q <= S_CLR;
							end else begin
								state_q <= S_OUT;
							end
						end else begin
							if (len_q != KLEN_W'(MAX_KEY_BYTES)) begin
								len_q <= len_q + KLEN_W'(1);
							end else begin
								ovf_q <= 1'b1;
							end
							if (q_data.key_last) begin
								kind_q      <= q_data.func;
								fresh_q     <= 1'b0;
								maybe_q     <= (q_data.func == FN_QUERY);
								toolong_q   <= ovf_n;
								seed_base_q <= 32'(q_data.collection_id * 32'(eff.hashes));
								probe_q     <= '0;
								if (ovf_n || !active || eff.hashes == '0) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_PROBE;
								end
							end
						end
					end
				end
				S_PROBE: begin
					h1_q    <= {32'h0, seed_base_q + 32'(probe_q)};
					h2_q    <= {32'h0, seed_base_q + 32'(probe_q)};
					base_q  <= '0;
					j_q     <= '0;
					state_q <= S_GRD;
				end
				S_GRD: begin
					bvalid_q <= addr_full < (KLEN_W + 1)'(len_q);
					state_q  <= S_GCAP;
				end
				S_GCAP: begin
					kbuf_q <= kb_n;
					j_q    <= j_q + 4'd1;
					if (j_q == 4'd15) begin
						full_q      <= (base_q + (KLEN_W + 1)'(16)) <= (KLEN_W + 1)'(len_q);
						mul_start_q <= 1'b1;
						mul_a_q     <= kb_n[63:0];
						mul_b_q     <= MM_C1;
						op_q        <= OP_K1A;
						state_q     <= S_MUL;
					end else begin
						state_q <= S_GRD;
					end
				end
				S_MUL: begin
					if (mul_done) begin
						case (op_q)
							OP_K1A: begin
								mul_start_q <= 1'b1;
								mul_a_q     <= rotl(mul_p, 31);
								mul_b_q     <= MM_C2;
								op_q        <= OP_K1B;
							end
							OP_K1B: begin
								h1_q <= h1_q ^ mul_p;
								if (full_q) begin
									state_q <= S_H1;
								end else begin
									mul_start_q <= 1'b1;
									mul_a_q     <= kbuf_q[127:64];
									mul_b_q     <= MM_C2;
									op_q        <= OP_K2A;
								end
							end
							OP_K2A: begin
								mul_start_q <= 1'b1;
								mul_a_q     <= rotl(mul_p, 33);
								mul_b_q     <= MM_C1;
								op_q        <= OP_K2B;
							end
							OP_K2B: begin
								h2_q    <= h2_q ^ mul_p;
								state_q <= full_q ? S_H2 : S_NEXT;
							end
							OP_FA, OP_FB: begin
								if (fsel_q) begin
									h2_q <= mul_p;
								end else begin
									h1_q <= mul_p;
								end
								fstep_q <= fstep_q + 2'd1;
								state_q <= S_FX;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_H1: begin
					h1_q    <= rotl(h1_q, 27) + h2_q;
					state_q <= S_H1B;
				end
				S_H1B: begin
					h1_q        <= (h1_q << 2) + h1_q + MM_HC1;
					mul_start_q <= 1'b1;
					mul_a_q     <= kbuf_q[127:64];
					mul_b_q     <= MM_C2;
					op_q        <= OP_K2A;
					state_q     <= S_MUL;
				end
				S_H2: begin
					h2_q    <= rotl(h2_q, 31) + h1_q;
					state_q <= S_H2B;
				end
				S_H2B: begin
					h2_q    <= (h2_q << 2) + h2_q + MM_HC2;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					base_q <= base_q + (KLEN_W + 1)'(16);
					if ((base_q + (KLEN_W + 1)'(16)) < (KLEN_W + 1)'(len_q)) begin
						j_q     <= '0;
						state_q <= S_GRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					h1_q    <= h1_q ^ 64'(len_q);
					h2_q    <= h2_q ^ 64'(len_q);
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					h1_q    <= h1_q + h2_q;
					state_q <= S_FIN3;
				end
				S_FIN3: begin
					h2_q    <= h2_q + h1_q;
					fsel_q  <= 1'b0;
					fstep_q <= '0;
					state_q <= S_FX;
				end
				S_FX: begin
					if (fsel_q) begin
						h2_q <= fx_s;
					end else begin
						h1_q <= fx_s;
					end
					case (fstep_q)
						2'd0: begin
							mul_start_q <= 1'b1;
							mul_a_q     <= fx_s;
							mul_b_q     <= MM_F1;
							op_q        <= OP_FA;
							state_q     <= S_MUL;
						end
						2'd1: begin
							mul_start_q <= 1'b1;
							mul_a_q     <= fx_s;
							mul_b_q     <= MM_F2;
							op_q        <= OP_FB;
							state_q     <= S_MUL;
						end
						default: begin
							if (!fsel_q) begin
								fsel_q  <= 1'b1;
								fstep_q <= '0;
							end else begin
								state_q <= S_FADD;
							end
						end
					endcase
				end
				S_FADD: begin
					h1_q    <= h1_q + h2_q;
					rem_q   <= '0;
					mcnt_q  <= '0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					rem_q  <= rem_n;
					h1_q   <= h1_q << 1;
					mcnt_q <= mcnt_q + 6'd1;
					if (mcnt_q == 6'd63) begin
						state_q <= S_MRD;
					end
				end
				S_MRD: begin
					state_q <= S_MCHK;
				end
				S_MCHK: begin
					if (kind_q == FN_ADD && !bitv) begin
						fresh_q <= 1'b1;
					end
					if (kind_q == FN_QUERY && !bitv) begin
						maybe_q <= 1'b0;
						state_q <= S_OUT;
					end else if ((probe_q + HC_W'(1)) < eff.hashes) begin
						probe_q <= probe_q + HC_W'(1);
						state_q <= S_PROBE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q                  <= 1'b1;
						out_data_q.maybe_present     <= maybe_q;
						out_data_q.newly_added       <= fresh_q;
						out_data_q.current_status    <= status_q;
						out_data_q.keys_counted      <= active ? cnt_n : '0;
						out_data_q.active_bits       <= active ? eff.bits : '0;
						out_data_q.active_hashes     <= active ? eff.hashes : '0;
						out_data_q.key_too_long      <= toolong_q;
						key_counter_q                <= cnt_n;
						if (kind_q != FN_STATUS) begin
							len_q <= '0;
							ovf_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/bfm_checker.sv =====
// port-level checks on the result channel of the bloom filter membership block
module bfm_checker import bfm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result beat changed while stalled");

	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.current_status == ST_DISABLED ||
		out_data.current_status == ST_PENDING) |->
		out_data.keys_counted == '0 && out_data.active_bits == '0 &&
		out_data.active_hashes == '0)
		else $error("inactive filter reports sizes or count");

	a_active_sized: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.current_status == ST_COMPACTING ||
		out_data.current_status == ST_ENABLED) |-> out_data.active_bits != '0)
		else $error("active filter reports zero size");

	a_added_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.newly_added |->
		!out_data.key_too_long && !out_data.maybe_present && out_data.keys_counted != '0)
		else $error("add result inconsistent");

endmodule

bind bloom_filter_membership bfm_checker u_bfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
